FILE: src/msr_pkg.sv
// Shared types and constants of the subscription router.
package msr_pkg;

    // Input request fields
    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] client_slot;
        logic [7:0] packet_byte;
        logic       packet_end;
    } t_req;

    typedef enum logic [2:0] {
        KIND_CONNACK  = 3'd0,
        KIND_SUBACK   = 3'd1,
        KIND_PINGRESP = 3'd2,
        KIND_FORWARD  = 3'd3,
        KIND_ASSIGNED = 3'd4,
        KIND_REJECTED = 3'd5
    } t_kind;

    // Result fields
    typedef struct packed {
        t_kind       result_kind;
        logic [2:0]  out_slot;
        logic [15:0] ack_packet_id;
        logic [5:0]  forward_topic_length;
        logic [7:0]  forward_payload_length;
        logic        run_last;
    } t_res;

    // Request types
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_OPEN  = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;

    // Control packet types (high nibble of the first byte)
    localparam logic [3:0] PKT_CONNECT    = 4'h1;
    localparam logic [3:0] PKT_PUBLISH    = 4'h3;
    localparam logic [3:0] PKT_SUBSCRIBE  = 4'h8;
    localparam logic [3:0] PKT_PINGREQ    = 4'hC;
    localparam logic [3:0] PKT_DISCONNECT = 4'hE;

    // Topic characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [8:0] POS_MAX     = 9'd511;
    localparam int         MAX_RESULTS = 40;
    localparam int         NRW         = $clog2(MAX_RESULTS + 1);

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_COPY_RD,
        S_COPY_WR,
        S_WALK,
        S_RD,
        S_EV,
        S_FLUSH
    } t_state;

    // Command to one slot cell
    typedef struct packed {
        logic open;
        logic close;
        logic inc;
    } t_cell_cmd;

endpackage

FILE: src/msr_slot_cell.sv
// One client slot cell: open flag, filter count and free-slot chain link.
module msr_slot_cell
    import msr_pkg::*;
#(
    parameter int CW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_cmd     i_cmd,
    input  logic          i_free_in,
    output logic          o_free_out,
    output logic          o_pick,
    output logic          o_open,
    output logic [CW-1:0] o_count
);

    logic          r_open;
    logic [CW-1:0] r_count;

    // Pass the "lower slot is free" flag up the row
    assign o_pick     = !r_open && !i_free_in;
    assign o_free_out = i_free_in || !r_open;
    assign o_open     = r_open;
    assign o_count    = r_count;

    // Hold slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_count <= '0;
        end else if (i_cmd.open) begin
            r_open  <= 1'b1;
            r_count <= '0;
        end else begin
            if (i_cmd.close) r_open <= 1'b0;
            if (i_cmd.inc) r_count <= r_count + CW'(1);
        end
    end

endmodule

FILE: src/msr_filter_store.sv
// Stored topic filters: byte memory plus per-entry length and fill count.
module msr_filter_store #(
    parameter  int NUM_ENTRIES = 40,
    parameter  int TOPIC_BYTES = 64,
    localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
    localparam int AW = $clog2(NUM_ENTRIES * TOPIC_BYTES),
    localparam int TW = $clog2(TOPIC_BYTES),
    localparam int RW = $clog2(TOPIC_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata,
    input  logic          i_mwe,
    input  logic [EW-1:0] i_mwaddr,
    input  logic [TW-1:0] i_mlen,
    input  logic [RW-1:0] i_mrcv,
    input  logic          i_mre,
    input  logic [EW-1:0] i_mraddr,
    output logic [TW-1:0] o_mlen,
    output logic [RW-1:0] o_mrcv
);

    logic [7:0]    mem     [NUM_ENTRIES * TOPIC_BYTES];
    logic [TW-1:0] len_mem [NUM_ENTRIES];
    logic [RW-1:0] rcv_mem [NUM_ENTRIES];
    logic [7:0]    r_rdata;
    logic [TW-1:0] r_mlen;
    logic [RW-1:0] r_mrcv;

    // Filter bytes
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= mem[i_raddr];
    end

    // Filter length and number of bytes received
    always_ff @(posedge i_clk) begin
        if (i_mwe) begin
            len_mem[i_mwaddr] <= i_mlen;
            rcv_mem[i_mwaddr] <= i_mrcv;
        end
        if (i_mre) begin
            r_mlen <= len_mem[i_mraddr];
            r_mrcv <= rcv_mem[i_mraddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_mlen  = r_mlen;
    assign o_mrcv  = r_mrcv;

endmodule

FILE: src/mqtt_subscription_router.sv
// Top level of the subscription router: parser, slot cell row, filter walk.
//
// Usage: one request is taken at a clock edge with start high and busy low.
// A request is an open or close event or one packet byte of a client slot.
// Results leave on o_res for exactly one cycle, marked by o_strobe; the
// receiver cannot stall, and run_last flags the last result of a request.
// Request handling:
//   open, close, non-final byte: busy stays low; an open result shows in
//   the cycle after the request.
//   final byte of an open slot: busy goes high while S_FIN finishes the
//   packet; its replies are registered out of S_FIN.
//   SUBSCRIBE with a stored filter: each received filter byte is copied
//   from the topic buffer into the filter memory in S_COPY_RD, S_COPY_WR.
//   PUBLISH: the walk moves past each slot cell in S_WALK; for each stored
//   filter of an open slot it reads the length in S_WALK, then runs match
//   steps of S_RD and S_EV, since each step waits on a registered read of
//   the filter and topic memories; S_FLUSH releases the last forward.
// Reset clears the slot cells, the parser and the controller; the filter
// memory needs no clearing, as only committed filters are read.
module mqtt_subscription_router
    import msr_pkg::*;
#(
    parameter int CLIENT_SLOTS     = 5,
    parameter int FILTERS_PER_SLOT = 8,
    parameter int TOPIC_BYTES      = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);

    localparam int NE  = CLIENT_SLOTS * FILTERS_PER_SLOT;
    localparam int EW  = (NE > 1) ? $clog2(NE) : 1;
    localparam int AW  = $clog2(NE * TOPIC_BYTES);
    localparam int TW  = $clog2(TOPIC_BYTES);
    localparam int RW  = $clog2(TOPIC_BYTES + 1);
    localparam int CW  = $clog2(FILTERS_PER_SLOT + 1);
    localparam int SW  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int SW1 = $clog2(CLIENT_SLOTS + 1);

    t_state           r_state, n_state;
    logic [8:0]       r_pos, n_pos;
    logic [3:0]       r_kind, n_kind;
    logic [7:0]       r_rl, n_rl;
    logic [15:0]      r_sid, n_sid;
    logic [15:0]      r_tl, n_tl;
    logic [RW-1:0]    r_trcv, n_trcv;
    logic [SW-1:0]    r_fslot, n_fslot;
    logic [SW1-1:0]   r_wi, n_wi;
    logic [CW-1:0]    r_wk, n_wk;
    logic [TW-1:0]    r_fi, n_fi;
    logic [TW-1:0]    r_ti, n_ti;
    logic             r_plus, n_plus;
    logic             r_pend, n_pend;
    logic [SW-1:0]    r_pslot, n_pslot;
    logic [NRW-1:0]   r_nres, n_nres;
    logic [7:0]       r_plen, n_plen;
    logic [TW-1:0]    r_j, n_j;
    logic [EW-1:0]    r_ce, n_ce;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    // Topic buffer
    logic [7:0]       r_tmem [TOPIC_BYTES];
    logic [7:0]       r_tdata;
    logic             tm_we, tm_re;
    logic [TW-1:0]    tm_waddr, tm_raddr;

    // Slot cell row
    t_cell_cmd        cell_cmd   [CLIENT_SLOTS];
    logic             cell_open  [CLIENT_SLOTS];
    logic             cell_pick  [CLIENT_SLOTS];
    logic [CW-1:0]    cell_count [CLIENT_SLOTS];
    logic             free_chain [CLIENT_SLOTS+1];
    logic             any_free;
    logic [SW-1:0]    pick_idx;

    // Filter store ports
    logic             fs_we, fs_re, fs_mwe, fs_mre;
    logic [AW-1:0]    fs_waddr, fs_raddr;
    logic [7:0]       fs_rdata;
    logic [EW-1:0]    fs_mwaddr, fs_mraddr;
    logic [TW-1:0]    fs_mlen, fs_wlen;
    logic [RW-1:0]    fs_mrcv;

    // Helpers
    logic             byte_ok;
    logic [8:0]       tw_idx;
    logic [10:0]      pl_calc;
    logic [EW-1:0]    e_walk, e_sub;
    logic [CW-1:0]    sub_count;
    logic [7:0]       f_ch, t_ch;
    logic [TW-1:0]    tl_n;

    function automatic t_res mk_res(t_kind k, logic [2:0] s, logic [15:0] pid,
                                    logic [5:0] tl, logic [7:0] pl, logic last);
        t_res r;
        r.result_kind            = k;
        r.out_slot               = s;
        r.ack_packet_id          = pid;
        r.forward_topic_length   = tl;
        r.forward_payload_length = pl;
        r.run_last               = last;
        return r;
    endfunction

    // Build the slot cell row
    assign free_chain[0] = 1'b0;
    for (genvar g = 0; g < CLIENT_SLOTS; g++) begin : g_cell
        msr_slot_cell #(.CW(CW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cell_cmd[g]),
            .i_free_in  (free_chain[g]),
            .o_free_out (free_chain[g+1]),
            .o_pick     (cell_pick[g]),
            .o_open     (cell_open[g]),
            .o_count    (cell_count[g])
        );
    end

    // Encode the picked free slot
    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < CLIENT_SLOTS; i++) begin
            if (cell_pick[i]) pick_idx = SW'(i);
        end
    end
    assign any_free = free_chain[CLIENT_SLOTS];

    msr_filter_store #(
        .NUM_ENTRIES (NE),
        .TOPIC_BYTES (TOPIC_BYTES)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (fs_we),
        .i_waddr  (fs_waddr),
        .i_wdata  (r_tdata),
        .i_re     (fs_re),
        .i_raddr  (fs_raddr),
        .o_rdata  (fs_rdata),
        .i_mwe    (fs_mwe),
        .i_mwaddr (fs_mwaddr),
        .i_mlen   (fs_wlen),
        .i_mrcv   (r_trcv),
        .i_mre    (fs_mre),
        .i_mraddr (fs_mraddr),
        .o_mlen   (fs_mlen),
        .o_mrcv   (fs_mrcv)
    );

    // Derived values
    assign byte_ok   = (int'(i_req.client_slot) < CLIENT_SLOTS)
                       && cell_open[SW'(i_req.client_slot)];
    assign tw_idx    = (r_kind == PKT_SUBSCRIBE) ? (r_pos - 9'd6) : (r_pos - 9'd4);
    assign tl_n      = r_tl[TW-1:0];
    assign pl_calc   = {3'b000, r_rl} - 11'd2 - {3'b000, 8'(r_tl)};
    assign e_walk    = EW'(int'(r_wi) * FILTERS_PER_SLOT + int'(r_wk));
    assign sub_count = cell_count[r_fslot];
    assign e_sub     = EW'(int'(r_fslot) * FILTERS_PER_SLOT + int'(sub_count));
    assign f_ch      = (RW'(r_fi) < fs_mrcv) ? fs_rdata : 8'h00;
    assign t_ch      = (RW'(r_ti) < r_trcv) ? r_tdata : 8'h00;
    assign fs_waddr  = AW'(int'(r_ce) * TOPIC_BYTES + int'(r_j));
    assign fs_raddr  = AW'(int'(e_walk) * TOPIC_BYTES + int'(r_fi));
    assign fs_mwaddr = e_sub;
    assign fs_mraddr = e_walk;
    assign fs_wlen   = tl_n;
    assign busy      = (r_state != S_IDLE);
    assign o_strobe  = r_out_valid;
    assign o_res     = r_out;

    // Topic buffer ports
    always_ff @(posedge i_clk) begin
        if (tm_we) r_tmem[tm_waddr] <= i_req.packet_byte;
        if (tm_re) r_tdata <= r_tmem[tm_raddr];
    end

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_kind      = r_kind;
        n_rl        = r_rl;
        n_sid       = r_sid;
        n_tl        = r_tl;
        n_trcv      = r_trcv;
        n_fslot     = r_fslot;
        n_wi        = r_wi;
        n_wk        = r_wk;
        n_fi        = r_fi;
        n_ti        = r_ti;
        n_plus      = r_plus;
        n_pend      = r_pend;
        n_pslot     = r_pslot;
        n_nres      = r_nres;
        n_plen      = r_plen;
        n_j         = r_j;
        n_ce        = r_ce;
        n_out_valid = 1'b0;
        n_out       = r_out;
        tm_we       = 1'b0;
        tm_waddr    = TW'(tw_idx);
        tm_re       = 1'b0;
        tm_raddr    = r_ti;
        fs_we       = 1'b0;
        fs_re       = 1'b0;
        fs_mwe      = 1'b0;
        fs_mre      = 1'b0;
        for (int i = 0; i < CLIENT_SLOTS; i++) cell_cmd[i] = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req.req_type)
                        REQ_OPEN: begin
                            n_out_valid = 1'b1;
                            if (any_free) begin
                                cell_cmd[pick_idx].open = 1'b1;
                                n_out = mk_res(KIND_ASSIGNED, 3'(pick_idx), '0, '0, '0, 1'b1);
                            end else begin
                                n_out = mk_res(KIND_REJECTED, '0, '0, '0, '0, 1'b1);
                            end
                        end
                        REQ_CLOSE: begin
                            if (int'(i_req.client_slot) < CLIENT_SLOTS)
                                cell_cmd[SW'(i_req.client_slot)].close = 1'b1;
                        end
                        REQ_BYTE: begin
                            // Parse one byte of an open slot
                            if (byte_ok) begin
                                if (r_pos == 9'd0) begin
                                    n_kind = i_req.packet_byte[7:4];
                                    n_rl   = '0;
                                    n_sid  = '0;
                                    n_tl   = '0;
                                    n_trcv = '0;
                                end else if (r_pos == 9'd1) begin
                                    n_rl = i_req.packet_byte;
                                end else if (r_kind == PKT_SUBSCRIBE) begin
                                    if (r_pos == 9'd2) n_sid[15:8] = i_req.packet_byte;
                                    else if (r_pos == 9'd3) n_sid[7:0] = i_req.packet_byte;
                                    else if (r_pos == 9'd4) n_tl[15:8] = i_req.packet_byte;
                                    else if (r_pos == 9'd5) n_tl[7:0] = i_req.packet_byte;
                                    else if (int'(tw_idx) < TOPIC_BYTES) begin
                                        tm_we  = 1'b1;
                                        n_trcv = RW'(int'(tw_idx) + 1);
                                    end
                                end else if (r_kind == PKT_PUBLISH) begin
                                    if (r_pos == 9'd2) n_tl[15:8] = i_req.packet_byte;
                                    else if (r_pos == 9'd3) n_tl[7:0] = i_req.packet_byte;
                                    else if (int'(tw_idx) < TOPIC_BYTES) begin
                                        tm_we  = 1'b1;
                                        n_trcv = RW'(int'(tw_idx) + 1);
                                    end
                                end
                                if (r_pos != POS_MAX) n_pos = r_pos + 9'd1;
                            end
                            if (i_req.packet_end) begin
                                n_pos = '0;
                                if (byte_ok) begin
                                    n_fslot = SW'(i_req.client_slot);
                                    n_state = S_FIN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_FIN: begin
                // Act on the completed packet
                n_state = S_IDLE;
                case (r_kind)
                    PKT_CONNECT: begin
                        n_out_valid = 1'b1;
                        n_out = mk_res(KIND_CONNACK, 3'(r_fslot), '0, '0, '0, 1'b1);
                    end
                    PKT_SUBSCRIBE: begin
                        n_out_valid = 1'b1;
                        n_out = mk_res(KIND_SUBACK, 3'(r_fslot), r_sid, '0, '0, 1'b1);
                        if ((int'(r_tl) < TOPIC_BYTES)
                            && (int'(sub_count) < FILTERS_PER_SLOT)) begin
                            fs_mwe = 1'b1;
                            cell_cmd[r_fslot].inc = 1'b1;
                            n_ce = e_sub;
                            n_j  = '0;
                            if (r_trcv != '0) n_state = S_COPY_RD;
                        end
                    end
                    PKT_PUBLISH: begin
                        if (int'(r_tl) < TOPIC_BYTES) begin
                            n_plen  = pl_calc[10] ? 8'h00 : pl_calc[7:0];
                            n_wi    = '0;
                            n_wk    = '0;
                            n_pend  = 1'b0;
                            n_nres  = '0;
                            n_state = S_WALK;
                        end
                    end
                    PKT_PINGREQ: begin
                        n_out_valid = 1'b1;
                        n_out = mk_res(KIND_PINGRESP, 3'(r_fslot), '0, '0, '0, 1'b1);
                    end
                    PKT_DISCONNECT: begin
                        cell_cmd[r_fslot].close = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            S_COPY_RD: begin
                tm_re    = 1'b1;
                tm_raddr = r_j;
                n_state  = S_COPY_WR;
            end

            S_COPY_WR: begin
                // Copy one topic byte into the new filter entry
                fs_we = 1'b1;
                if (RW'(r_j) + RW'(1) == r_trcv) begin
                    n_state = S_IDLE;
                end else begin
                    n_j     = r_j + TW'(1);
                    n_state = S_COPY_RD;
                end
            end

            S_WALK: begin
                // Advance to the next stored filter of an open slot, or flush after the last slot
                if (int'(r_wi) >= CLIENT_SLOTS) begin
                    n_state = S_FLUSH;
                end else if (cell_open[SW'(r_wi)]
                             && (r_wk < cell_count[SW'(r_wi)])) begin
                    fs_mre  = 1'b1;
                    n_fi    = '0;
                    n_ti    = '0;
                    n_plus  = 1'b0;
                    n_state = S_RD;
                end else begin
                    n_wi = r_wi + SW1'(1);
                    n_wk = '0;
                end
            end

            S_RD: begin
                fs_re    = 1'b1;
                tm_re    = 1'b1;
                tm_raddr = r_ti;
                n_state  = S_EV;
            end

            S_EV: begin
                // One step of the wildcard match
                n_state = S_RD;
                if (r_plus) begin
                    if ((r_ti < tl_n) && (t_ch != CH_SLASH)) begin
                        n_ti = r_ti + TW'(1);
                    end else begin
                        n_fi   = r_fi + TW'(1);
                        n_plus = 1'b0;
                    end
                end else if ((r_fi < fs_mlen) && (r_ti < tl_n)) begin
                    if (f_ch == CH_HASH) begin
                        n_state = S_WALK;
                    end else if (f_ch == CH_PLUS) begin
                        n_plus = 1'b1;
                    end else if (f_ch != t_ch) begin
                        n_state = S_WALK;
                    end else begin
                        n_fi = r_fi + TW'(1);
                        n_ti = r_ti + TW'(1);
                    end
                end else begin
                    n_state = S_WALK;
                end

                if (n_state == S_WALK) begin
                    n_wk = r_wk + CW'(1);
                    // Hold a match back until the next one shows whether it is last
                    if ((!r_plus && (r_fi < fs_mlen) && (r_ti < tl_n) && (f_ch == CH_HASH))
                        || (!((r_fi < fs_mlen) && (r_ti < tl_n))
                            && (((r_fi == fs_mlen) && (r_ti == tl_n))
                                || (({1'b0, r_fi} + 1'b1 == {1'b0, fs_mlen})
                                    && (f_ch == CH_HASH))))) begin
                        if (int'(r_nres) < MAX_RESULTS) begin
                            if (r_pend) begin
                                n_out_valid = 1'b1;
                                n_out = mk_res(KIND_FORWARD, 3'(r_pslot), '0,
                                               6'(r_tl), r_plen, 1'b0);
                            end
                            n_pend  = 1'b1;
                            n_pslot = SW'(r_wi);
                            n_nres  = r_nres + NRW'(1);
                        end
                    end
                end
            end

            S_FLUSH: begin
                // Release the last forward
                if (r_pend) begin
                    n_out_valid = 1'b1;
                    n_out = mk_res(KIND_FORWARD, 3'(r_pslot), '0, 6'(r_tl), r_plen, 1'b1);
                end
                n_pend  = 1'b0;
                n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_kind      <= '0;
            r_rl        <= '0;
            r_sid       <= '0;
            r_tl        <= '0;
            r_trcv      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_kind      <= n_kind;
            r_rl        <= n_rl;
            r_sid       <= n_sid;
            r_tl        <= n_tl;
            r_trcv      <= n_trcv;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_fslot <= n_fslot;
        r_wi    <= n_wi;
        r_wk    <= n_wk;
        r_fi    <= n_fi;
        r_ti    <= n_ti;
        r_plus  <= n_plus;
        r_pslot <= n_pslot;
        r_nres  <= n_nres;
        r_plen  <= n_plen;
        r_j     <= n_j;
        r_ce    <= n_ce;
        r_out   <= n_out;
    end

endmodule

FILE: src/msr_checker.sv
// Port-level checks of the subscription router, bound to its top level.
module msr_checker
    import msr_pkg::*;
#(
    parameter int CLIENT_SLOTS = 5
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_strobe,
    input t_res o_res
);

    // An open request answers in the next cycle as a single result
    a_open_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy && (i_req.req_type == REQ_OPEN))
        |=> (o_strobe && o_res.run_last
             && ((o_res.result_kind == KIND_ASSIGNED)
                 || (o_res.result_kind == KIND_REJECTED))))
        else $error("open request not answered in the next cycle");

    // Slot answers come only from an open request
    a_open_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ((o_res.result_kind == KIND_ASSIGNED)
                      || (o_res.result_kind == KIND_REJECTED)))
        |-> $past(start && !busy && (i_req.req_type == REQ_OPEN)))
        else $error("slot answer without an open request");

    // An assigned slot lies in range
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_res.result_kind == KIND_ASSIGNED))
        |-> (int'(o_res.out_slot) < CLIENT_SLOTS))
        else $error("assigned slot out of range");

    // Replies come only from a final packet byte
    a_reply_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ((o_res.result_kind == KIND_CONNACK)
                      || (o_res.result_kind == KIND_SUBACK)
                      || (o_res.result_kind == KIND_PINGRESP)))
        |-> $past(start && !busy && i_req.packet_end
                  && (i_req.req_type == REQ_BYTE), 2))
        else $error("reply without a final packet byte");

endmodule

bind mqtt_subscription_router msr_checker #(
    .CLIENT_SLOTS (CLIENT_SLOTS)
) u_msr_checker (.*);
